// ===== src/wsfd_pkg.sv =====
// Shared types and constants for the WebSocket frame decoder.
package wsfd_pkg;

  localparam int unsigned MAX_LEN_W = 63;
  localparam int unsigned CMP_W     = 64;

  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 63'd65536;

  typedef enum logic [1:0] {
    ST_DATA    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_CLOSE   = 2'd2,
    ST_TOOLONG = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FH_DELIVER = 2'd0,
    FH_CLOSE   = 2'd1,
    FH_ERROR   = 2'd2
  } handling_t;

  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXT     = 5'b00100,
    PH_MASK    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  // One pending result: raw byte and mask key byte, unmasked in the back end.
  typedef struct packed {
    logic [7:0] raw_byte;
    logic [7:0] key_byte;
    status_t    status;
    logic [3:0] opcode;
    logic       frame_end;
  } result_t;

endpackage

// ===== src/wsfd_parser.sv =====
// Front end: header parsing, length check and payload classification.
module wsfd_parser #(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          byte_valid,
  input  logic [7:0]                    byte_in,
  input  logic                          cfg_we,
  input  logic [wsfd_pkg::MAX_LEN_W-1:0] cfg_max,
  output logic                          push,
  output wsfd_pkg::result_t             push_item
);

  localparam logic [LENGTH_BITS-1:0] LEN_ALL1 = {LENGTH_BITS{1'b1}};

  wsfd_pkg::phase_t                 phase_r, phase_nxt;
  wsfd_pkg::handling_t              fh_r, fh_nxt;
  logic [3:0]                       opcode_r, opcode_nxt;
  logic                             mask_present_r, mask_present_nxt;
  logic [3:0]                       ext_left_r, ext_left_nxt;
  logic [LENGTH_BITS-1:0]           flen_r, flen_nxt;
  logic [31:0]                      mask_key_r, mask_key_nxt;
  logic [2:0]                       mask_left_r, mask_left_nxt;
  logic [LENGTH_BITS-1:0]           pl_left_r, pl_left_nxt;
  logic [1:0]                       pos_r, pos_nxt;
  logic [wsfd_pkg::MAX_LEN_W-1:0]   max_r;

  logic                             ld;
  logic                             ld_mp;
  logic [LENGTH_BITS-1:0]           ld_len;
  logic [LENGTH_BITS-1:0]           ext_len;
  logic                             too_long;
  logic [7:0]                       key_sel;

  assign ext_len = (flen_r[LENGTH_BITS-1 -: 8] != 8'd0) ? LEN_ALL1
                                                         : {flen_r[LENGTH_BITS-9:0], byte_in};
  assign too_long = wsfd_pkg::CMP_W'(ld_len) > {1'b0, max_r};

  always_comb begin
    case (pos_r)
      2'd0: key_sel = mask_key_r[31:24];
      2'd1: key_sel = mask_key_r[23:16];
      2'd2: key_sel = mask_key_r[15:8];
      default: key_sel = mask_key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt        = phase_r;
    fh_nxt           = fh_r;
    opcode_nxt       = opcode_r;
    mask_present_nxt = mask_present_r;
    ext_left_nxt     = ext_left_r;
    flen_nxt         = flen_r;
    mask_key_nxt     = mask_key_r;
    mask_left_nxt    = mask_left_r;
    pl_left_nxt      = pl_left_r;
    pos_nxt          = pos_r;
    ld               = 1'b0;
    ld_mp            = mask_present_r;
    ld_len           = ext_len;
    push             = 1'b0;
    push_item        = '{raw_byte: 8'd0, key_byte: 8'd0, status: wsfd_pkg::ST_EMPTY,
                         opcode: opcode_r, frame_end: 1'b1};
    if (byte_valid) begin
      unique case (phase_r)
        wsfd_pkg::PH_HDR1: begin
          mask_present_nxt = byte_in[7];
          ld_mp            = byte_in[7];
          flen_nxt         = '0;
          if (byte_in[6:0] == wsfd_pkg::LEN7_EXT16) begin
            ext_left_nxt = 4'd2;
            phase_nxt    = wsfd_pkg::PH_EXT;
          end else if (byte_in[6:0] == wsfd_pkg::LEN7_EXT64) begin
            ext_left_nxt = 4'd8;
            phase_nxt    = wsfd_pkg::PH_EXT;
          end else begin
            ld     = 1'b1;
            ld_len = LENGTH_BITS'(byte_in[6:0]);
          end
        end
        wsfd_pkg::PH_EXT: begin
          flen_nxt     = ext_len;
          ext_left_nxt = ext_left_r - 4'd1;
          ld           = (ext_left_r == 4'd1);
        end
        wsfd_pkg::PH_MASK: begin
          mask_key_nxt  = {mask_key_r[23:0], byte_in};
          mask_left_nxt = mask_left_r - 3'd1;
          if (mask_left_r == 3'd1) begin
            if (pl_left_r != '0) begin
              phase_nxt = wsfd_pkg::PH_PAYLOAD;
            end else begin
              phase_nxt        = wsfd_pkg::PH_HDR0;
              push             = (fh_r != wsfd_pkg::FH_ERROR);
              push_item.status = (fh_r == wsfd_pkg::FH_CLOSE) ? wsfd_pkg::ST_CLOSE
                                                               : wsfd_pkg::ST_EMPTY;
            end
          end
        end
        wsfd_pkg::PH_PAYLOAD: begin
          pl_left_nxt = pl_left_r - LENGTH_BITS'(1);
          pos_nxt     = pos_r + 2'd1;
          if (pl_left_nxt == '0) phase_nxt = wsfd_pkg::PH_HDR0;
          if (fh_r == wsfd_pkg::FH_DELIVER) begin
            push                = 1'b1;
            push_item.raw_byte  = byte_in;
            push_item.key_byte  = mask_present_r ? key_sel : 8'd0;
            push_item.status    = wsfd_pkg::ST_DATA;
            push_item.frame_end = (pl_left_nxt == '0);
          end else if (fh_r == wsfd_pkg::FH_CLOSE && pl_left_nxt == '0) begin
            push             = 1'b1;
            push_item.status = wsfd_pkg::ST_CLOSE;
          end
        end
        default: begin
          opcode_nxt = byte_in[3:0];
          phase_nxt  = wsfd_pkg::PH_HDR1;
        end
      endcase

      if (ld) begin
        flen_nxt      = ld_len;
        pl_left_nxt   = ld_len;
        pos_nxt       = 2'd0;
        mask_left_nxt = ld_mp ? 3'd4 : 3'd0;
        if (too_long) begin
          fh_nxt           = wsfd_pkg::FH_ERROR;
          push             = 1'b1;
          push_item.status = wsfd_pkg::ST_TOOLONG;
        end else begin
          fh_nxt = (opcode_r == wsfd_pkg::OPC_CLOSE) ? wsfd_pkg::FH_CLOSE
                                                     : wsfd_pkg::FH_DELIVER;
        end
        if (ld_mp) begin
          phase_nxt = wsfd_pkg::PH_MASK;
        end else if (ld_len != '0) begin
          phase_nxt = wsfd_pkg::PH_PAYLOAD;
        end else begin
          phase_nxt = wsfd_pkg::PH_HDR0;
          if (!too_long) begin
            push             = 1'b1;
            push_item.status = (opcode_r == wsfd_pkg::OPC_CLOSE) ? wsfd_pkg::ST_CLOSE
                                                                 : wsfd_pkg::ST_EMPTY;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= wsfd_pkg::PH_HDR0;
      fh_r           <= wsfd_pkg::FH_DELIVER;
      opcode_r       <= 4'd0;
      mask_present_r <= 1'b0;
      ext_left_r     <= 4'd0;
      flen_r         <= '0;
      mask_key_r     <= 32'd0;
      mask_left_r    <= 3'd0;
      pl_left_r      <= '0;
      pos_r          <= 2'd0;
      max_r          <= wsfd_pkg::MAX_LEN_RESET;
    end else begin
      phase_r        <= phase_nxt;
      fh_r           <= fh_nxt;
      opcode_r       <= opcode_nxt;
      mask_present_r <= mask_present_nxt;
      ext_left_r     <= ext_left_nxt;
      flen_r         <= flen_nxt;
      mask_key_r     <= mask_key_nxt;
      mask_left_r    <= mask_left_nxt;
      pl_left_r      <= pl_left_nxt;
      pos_r          <= pos_nxt;
      if (cfg_we) max_r <= cfg_max;
    end
  end

endmodule

// ===== src/wsfd_queue.sv =====
// Two-entry result queue between parser and output stage.
module wsfd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wsfd_pkg::result_t push_item,
  output logic              has_room,
  input  logic              pop,
  output logic              not_empty,
  output wsfd_pkg::result_t head
);

  wsfd_pkg::result_t mem_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        count_r;

  assign has_room  = (count_r != 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== src/wsfd_emitter.sv =====
// Back end: unmasks payload bytes into the output register.
module wsfd_emitter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  wsfd_pkg::result_t q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_data,
  output logic [1:0]        out_status,
  output logic [3:0]        out_frame_opc,
  output logic              out_end
);

  logic       valid_r;
  logic [7:0] data_r;
  logic [1:0] status_r;
  logic [3:0] opcode_r;
  logic       end_r;

  assign q_pop         = q_valid && (!valid_r || out_ready);
  assign out_valid     = valid_r;
  assign out_data      = data_r;
  assign out_status    = status_r;
  assign out_frame_opc = opcode_r;
  assign out_end       = end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_ready) begin
      valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r   <= q_head.raw_byte ^ q_head.key_byte;
      status_r <= q_head.status;
      opcode_r <= q_head.opcode;
      end_r    <= q_head.frame_end;
    end
  end

endmodule

// ===== src/websocket_frame_decoder.sv =====
// Top level of the byte-serial WebSocket frame decoder.
// Input: one received byte per word on in_tvalid/in_tready/in_tdata.
// Output: at most one result word per input byte on out_*: tdata is the
//   unmasked payload byte (0 for non-payload results), tuser carries status
//   (0 payload, 1 empty data frame, 2 close frame ended, 3 frame too long)
//   and the frame opcode, tlast marks the last result of a frame.
// Config: cfg_valid/cfg_ready/cfg_data writes max_payload_len (63 bits,
//   reset 65536); cfg_ready is always high. Write only while idle.
// Throughput: one byte per cycle sustained while out_tready stays high; the
//   parser handles every header, mask and payload byte as it is accepted.
// Path: a result enters the queue at the edge that accepts its byte, then
//   moves into the output register, which drives out_tvalid and the data.
// Stall: a two-entry queue sits between parser and output register; when
//   out_tready is low the queue fills and in_tready drops, no word is lost.
// Reset: synchronous active-low rst_n returns the parser to the first header
//   byte, empties the queue and restores the length limit.
module websocket_frame_decoder #(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] rx_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] data_byte
  output logic [5:0]                     out_tuser,  // [1:0] status, [5:2] frame_opcode
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wsfd_pkg::MAX_LEN_W-1:0] cfg_data
);

  logic              push, has_room, q_valid, q_pop;
  wsfd_pkg::result_t push_item, q_head;

  assign in_tready = has_room;
  assign cfg_ready = 1'b1;

  wsfd_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_valid(in_tvalid && has_room),
    .byte_in   (in_tdata),
    .cfg_we    (cfg_valid),
    .cfg_max   (cfg_data),
    .push      (push),
    .push_item (push_item)
  );

  wsfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .has_room (has_room),
    .pop      (q_pop),
    .not_empty(q_valid),
    .head     (q_head)
  );

  wsfd_emitter u_emitter (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_data     (out_tdata),
    .out_status   (out_tuser[1:0]),
    .out_frame_opc(out_tuser[5:2]),
    .out_end      (out_tlast)
  );

endmodule
